FILE: src/plm_pkg.sv
`default_nettype none

package plm_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;

  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int CMP_BITS   = ((COUNT_BITS > 5) ? COUNT_BITS : 5) + 1;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_INS_POS   = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_DEL_BACK  = 3'd4;
  localparam logic [2:0] OP_DEL_POS   = 3'd5;
  localparam logic [2:0] OP_DISPLAY   = 3'd6;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_POS = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;
  localparam logic [1:0] CELL_ROT  = 2'd3;

  typedef logic [VALUE_BITS-1:0] elem_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [IDX_BITS-1:0] idx;
    logic [IDX_BITS-1:0] last_idx;
    elem_t               value;
  } cell_ctl_t;

  function automatic elem_t fit_value(logic [31:0] raw);
    logic signed [63:0] t;
    t = 64'(signed'(raw));
    return t[VALUE_BITS-1:0];
  endfunction

  function automatic logic [31:0] to_word(elem_t v);
    logic signed [63:0] t;
    t = 64'(signed'(v));
    return t[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/positional_list_engine.sv
// An accepted word's result is registered straight into the output register, and a new edit
// is taken every cycle while the output side keeps up.
// Display of n elements sends n words, one a cycle while the output side keeps up, by rotating
// the cell chain once per word; no input is taken until the last word is sent (one word for an
// empty list). Reset clears the element count, the display sequencer and the output valid; the
// cells themselves are not cleared.
`default_nettype none

module positional_list_engine
  import plm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // operation[2:0], value[34:3], position[39:35]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // status[1:0], element_count[6:2], element_value[38:7]
  output logic             m_tlast
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SHOW = 1'b1;

  logic                  state;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] remaining;

  logic [2:0]            operation;
  logic [31:0]           value;
  logic [4:0]            position;

  logic                  out_free;
  logic                  accept;
  logic                  show_emit;

  logic [CMP_BITS-1:0]   pos_w;
  logic [CMP_BITS-1:0]   cnt_w;
  logic                  full;
  logic                  empty;

  cell_ctl_t             ctl;
  logic [1:0]            status;
  logic [COUNT_BITS-1:0] count_next;
  logic                  load_edit;
  logic                  start_show;

  elem_t                 cells [CAPACITY];

  assign operation = s_tdata[2:0];
  assign value     = s_tdata[34:3];
  assign position  = s_tdata[39:35];

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign show_emit = (state == ST_SHOW) && out_free;

  assign pos_w = CMP_BITS'(position);
  assign cnt_w = CMP_BITS'(count);
  assign full  = (count == COUNT_BITS'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    ctl.mode     = CELL_HOLD;
    ctl.idx      = '0;
    ctl.last_idx = IDX_BITS'(count - 1'b1);
    ctl.value    = fit_value(value);
    status       = STAT_OK;
    count_next   = count;
    load_edit    = 1'b0;
    start_show   = 1'b0;
    if (show_emit) begin
      ctl.mode = CELL_ROT;
    end else if (accept) begin
      load_edit = 1'b1;
      case (operation)
        OP_INS_FRONT, OP_INS_BACK: begin
          if (full) begin
            status = STAT_FULL;
          end else begin
            ctl.mode   = CELL_INS;
            ctl.idx    = (operation == OP_INS_FRONT) ? '0 : IDX_BITS'(count);
            count_next = count + 1'b1;
          end
        end
        OP_INS_POS: begin
          if (pos_w == '0 || pos_w > cnt_w + 1'b1) begin
            status = STAT_BAD_POS;
          end else if (full) begin
            status = STAT_FULL;
          end else begin
            ctl.mode   = CELL_INS;
            ctl.idx    = IDX_BITS'(pos_w - 1'b1);
            count_next = count + 1'b1;
          end
        end
        OP_DEL_FRONT, OP_DEL_BACK: begin
          if (empty) begin
            status = STAT_EMPTY;
          end else begin
            ctl.mode   = CELL_DEL;
            ctl.idx    = (operation == OP_DEL_FRONT) ? '0 : IDX_BITS'(count - 1'b1);
            count_next = count - 1'b1;
          end
        end
        OP_DEL_POS: begin
          if (empty) begin
            status = STAT_EMPTY;
          end else if (pos_w == '0 || pos_w > cnt_w) begin
            status = STAT_BAD_POS;
          end else begin
            ctl.mode   = CELL_DEL;
            ctl.idx    = IDX_BITS'(pos_w - 1'b1);
            count_next = count - 1'b1;
          end
        end
        OP_DISPLAY: begin
          if (!empty) begin
            load_edit  = 1'b0;
            start_show = 1'b1;
          end
        end
        default: status = STAT_OK;
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    elem_t left_in;
    elem_t right_in;
    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cells[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cells[g+1];
    end
    plm_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .slot  (IDX_BITS'(g)),
      .left  (left_in),
      .right (right_in),
      .head  (cells[0]),
      .q     (cells[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remaining <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      count <= count_next;
      if (start_show) begin
        state     <= ST_SHOW;
        remaining <= count;
      end else if (show_emit) begin
        remaining <= remaining - 1'b1;
        if (remaining == COUNT_BITS'(1)) begin
          state <= ST_IDLE;
        end
      end
      if (load_edit || show_emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (show_emit) begin
      m_tdata <= {1'b0, to_word(cells[0]), 5'(count), STAT_OK};
      m_tlast <= (remaining == COUNT_BITS'(1));
    end else if (load_edit) begin
      m_tdata <= {1'b0, 32'd0, 5'(count_next), status};
      m_tlast <= 1'b1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(CAPACITY))
    else $error("element count above capacity");

  a_show_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHOW) |-> !s_tready)
    else $error("input taken during display");

  a_show_remaining: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHOW) |-> (remaining != '0))
    else $error("display running with nothing left");

  a_show_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHOW) |=> (count == $past(count)))
    else $error("count changed during display");

  a_show_last: assert property (@(posedge clk) disable iff (rst)
    (show_emit && remaining == COUNT_BITS'(1)) |=> (state == ST_IDLE && m_tlast))
    else $error("display did not end on its last word");

endmodule

`default_nettype wire

FILE: src/plm_cell.sv
`default_nettype none

module plm_cell
  import plm_pkg::*;
(
  input  wire logic                clk,
  input  wire cell_ctl_t           ctl,
  input  wire logic [IDX_BITS-1:0] slot,
  input  wire elem_t               left,
  input  wire elem_t               right,
  input  wire elem_t               head,
  output elem_t                    q
);

  elem_t q_next;

  always_comb begin
    q_next = q;
    case (ctl.mode)
      CELL_HOLD: q_next = q;
      CELL_INS: begin
        if (slot > ctl.idx) begin
          q_next = left;
        end else if (slot == ctl.idx) begin
          q_next = ctl.value;
        end
      end
      CELL_DEL: begin
        if (slot >= ctl.idx) begin
          q_next = right;
        end
      end
      CELL_ROT: begin
        if (slot == ctl.last_idx) begin
          q_next = head;
        end else begin
          q_next = right;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire
